// ----- rtl/lud_pkg.sv -----
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, constants and helpers for the Doolittle LU decomposition block.
// ----------------------------------------------------------------------------
package lud_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_W        = 16;
	localparam int IDX_W         = 3;
	localparam int SIZE_W        = 4;
	localparam int DEF_MAX_ORDER = 8;
	localparam int DIV_STEPS     = DATA_W + FRAC_W;   // quotient bits
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	// APB register indexes
	localparam logic REG_MATRIX_SIZE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_PIV_RD,
		ST_PIV_CHK,
		ST_COL_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_SUB,
		ST_OUT_RD,
		ST_OUT_EMIT,
		ST_FAIL
	} lud_state_t;

	// linear position of (r, c) in an n-wide row-major layout
	function automatic logic [6:0] lud_idx(input logic [IDX_W-1:0] r,
	                                       input logic [IDX_W-1:0] c,
	                                       input logic [SIZE_W-1:0] n);
		logic [6:0] base;
		base = 7'(r) * 7'(n);
		return base + 7'(c);
	endfunction

endpackage

// ----- rtl/lud_div.sv -----
// ----------------------------------------------------------------------------
// lud_div
// Radix-2 restoring divider: (num << 16) / den, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module lud_div import lud_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] num_in,
	input  logic signed [DATA_W-1:0] den_in,
	output logic                     done,
	output logic signed [DATA_W-1:0] quo
);

	logic                  act_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIV_STEPS-1:0]  dvd_q;   // dividend in, quotient out
	logic [DATA_W:0]       rem_q;
	logic [DATA_W-1:0]     den_q;
	logic                  neg_q;

	logic [DATA_W-1:0]     num_mag;
	logic [DATA_W-1:0]     den_mag;
	logic [DATA_W:0]       rem_sh;
	logic                  fits;

	assign num_mag = num_in[DATA_W-1] ? (~num_in + 1'b1) : num_in;
	assign den_mag = den_in[DATA_W-1] ? (~den_in + 1'b1) : den_in;
	assign rem_sh  = {rem_q[DATA_W-1:0], dvd_q[DIV_STEPS-1]};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den_mag;
			neg_q <= num_in[DATA_W-1] ^ den_in[DATA_W-1];
		end else if (act_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			dvd_q <= {dvd_q[DIV_STEPS-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (dvd_q > DIV_STEPS'(33'h0_8000_0000))
				quo = {1'b1, {(DATA_W-1){1'b0}}};
			else
				quo = -$signed(dvd_q[DATA_W-1:0]);
		end else begin
			if (dvd_q > DIV_STEPS'(32'h7FFF_FFFF))
				quo = {1'b0, {(DATA_W-1){1'b1}}};
			else
				quo = $signed(dvd_q[DATA_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/lu_decomposition_doolittle_top.sv -----
// ----------------------------------------------------------------------------
// lu_decomposition_doolittle_top
// Doolittle LU decomposition without pivoting on a Q16.16 square matrix.
// ----------------------------------------------------------------------------
// Usage:
//  - Load: one element per transaction (start high while busy low), row-major.
//    Elements past n*n are dropped. The transaction with is_last set starts
//    the run; busy stays high until the last result has been shown.
//  - Run: the stored matrix is copied to a work memory (COPY_RD, then COPY_WR,
//    per element), then eliminated in place. Each multiplier goes through a
//    shared 48-step restoring divider; each update of an element passes
//    through the one work-memory read port and a 32x32 multiplier.
//  - Results: n*n strobes of out_valid, row-major, with
//    out_row/out_col and out_last on the final one. A zero pivot yields a
//    single strobe with failed and out_last set instead.
//  - At n = 8 the run time of a full matrix is set mostly by the serial
//    divider. The receiver cannot stall; results are not held.
//  - matrix_size (APB, address 0, bits 3:0 kept) must be written only while
//    idle; the block itself does not enforce this. 0 acts as 1 and values
//    above MAX_ORDER act as MAX_ORDER. Reset sets it to MAX_ORDER and clears
//    the load count; memory contents are not cleared.
// ----------------------------------------------------------------------------
module lu_decomposition_doolittle_top import lud_pkg::*; #(
	parameter int MAX_ORDER = DEF_MAX_ORDER
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// APB configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	// element input
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] element_value,
	input  logic                     is_last,
	// results
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] out_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic                     failed,
	output logic                     out_last
);

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// configuration
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_use;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? 32'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_ORDER);
		end else if (cfg_wr) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	always_comb begin
		if (size_q == '0)
			n_use = SIZE_W'(1);
		else if (size_q > SIZE_W'(MAX_ORDER))
			n_use = SIZE_W'(MAX_ORDER);
		else
			n_use = size_q;
	end

	// sequencer state and counters
	lud_state_t        state_q, state_d;
	logic [SIZE_W-1:0] n_q;
	logic [CNT_W-1:0]  load_q;
	logic [CNT_W-1:0]  cidx_q, cidx_d;
	logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
	logic              in_acc;
	logic [CNT_W-1:0]  nn_use, nn_q;

	assign busy   = (state_q != ST_IDLE);
	assign in_acc = start && !busy;
	assign nn_use = CNT_W'(n_use) * CNT_W'(n_use);
	assign nn_q   = CNT_W'(n_q) * CNT_W'(n_q);

	// memories: input store and work matrix
	logic signed [DATA_W-1:0] store_mem [DEPTH];
	logic signed [DATA_W-1:0] work_mem  [DEPTH];
	logic signed [DATA_W-1:0] store_rd_q;
	logic signed [DATA_W-1:0] work_rd_q;
	logic [AW-1:0]            work_raddr;
	logic [AW-1:0]            work_waddr;
	logic                     work_we;
	logic signed [DATA_W-1:0] work_wdata;

	always_ff @(posedge clk) begin
		if (in_acc && (load_q < nn_use))
			store_mem[load_q[AW-1:0]] <= element_value;
		store_rd_q <= store_mem[cidx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (work_we)
			work_mem[work_waddr] <= work_wdata;
		work_rd_q <= work_mem[work_raddr];
	end

	// arithmetic
	logic signed [DATA_W-1:0]   p_q;
	logic signed [DATA_W-1:0]   m_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic signed [2*DATA_W-1:0] prod_sh;
	logic signed [DATA_W+16:0]  diff;
	logic signed [DATA_W-1:0]   diff_sat;
	logic                       div_start;
	logic                       div_done;
	logic signed [DATA_W-1:0]   div_quo;

	lud_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_in (work_rd_q),
		.den_in (p_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// floor(m * a / 2^16) by arithmetic shift, then saturating subtract
	assign prod_sh = prod_q >>> FRAC_W;
	assign diff    = $signed({{17{work_rd_q[DATA_W-1]}}, work_rd_q})
	               - prod_sh[DATA_W+16:0];

	always_comb begin
		if (diff[DATA_W+16:DATA_W-1] == '0 || diff[DATA_W+16:DATA_W-1] == '1)
			diff_sat = diff[DATA_W-1:0];
		else if (diff[DATA_W+16])
			diff_sat = {1'b1, {(DATA_W-1){1'b0}}};
		else
			diff_sat = {1'b0, {(DATA_W-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PIV_CHK)
			p_q <= work_rd_q;
		if (state_q == ST_DIV_WAIT && div_done)
			m_q <= div_quo;
		if (state_q == ST_UPD_MUL)
			prod_q <= m_q * work_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			load_q  <= '0;
			n_q     <= SIZE_W'(MAX_ORDER);
			cidx_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cidx_q  <= cidx_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			if (in_acc) begin
				if (is_last) begin
					load_q <= '0;
					n_q    <= n_use;
				end else if (load_q < nn_use) begin
					load_q <= load_q + 1'b1;
				end
			end
		end
	end

	// next state, memory control, result strobes
	logic [SIZE_W-1:0] i_nx, j_nx, k_nx;

	assign i_nx = SIZE_W'(i_q) + 1'b1;
	assign j_nx = SIZE_W'(j_q) + 1'b1;
	assign k_nx = SIZE_W'(k_q) + 1'b1;

	always_comb begin
		state_d    = state_q;
		cidx_d     = cidx_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		work_raddr = AW'(lud_idx(i_q, j_q, n_q));
		work_waddr = cidx_q[AW-1:0];
		work_we    = 1'b0;
		work_wdata = store_rd_q;
		div_start  = 1'b0;
		out_valid  = 1'b0;
		out_value  = work_rd_q;
		out_row    = i_q;
		out_col    = j_q;
		failed     = 1'b0;
		out_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && is_last) begin
					cidx_d  = '0;
					state_d = ST_COPY_RD;
				end
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				work_we = 1'b1;
				cidx_d  = cidx_q + 1'b1;
				if (cidx_q + 1'b1 == nn_q) begin
					i_d     = '0;
					state_d = ST_PIV_RD;
				end else begin
					state_d = ST_COPY_RD;
				end
			end
			ST_PIV_RD: begin
				work_raddr = AW'(lud_idx(i_q, i_q, n_q));
				state_d    = ST_PIV_CHK;
			end
			ST_PIV_CHK: begin
				if (work_rd_q == '0) begin
					state_d = ST_FAIL;
				end else if (i_nx == n_q) begin
					i_d     = '0;
					j_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					k_d     = i_nx[IDX_W-1:0];
					state_d = ST_COL_RD;
				end
			end
			ST_COL_RD: begin
				work_raddr = AW'(lud_idx(k_q, i_q, n_q));
				state_d    = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				work_waddr = AW'(lud_idx(k_q, i_q, n_q));
				work_wdata = div_quo;
				if (div_done) begin
					work_we = 1'b1;
					j_d     = i_nx[IDX_W-1:0];
					state_d = ST_UPD_RD;
				end
			end
			ST_UPD_RD: begin
				work_raddr = AW'(lud_idx(i_q, j_q, n_q));
				state_d    = ST_UPD_MUL;
			end
			ST_UPD_MUL: begin
				work_raddr = AW'(lud_idx(k_q, j_q, n_q));
				state_d    = ST_UPD_SUB;
			end
			ST_UPD_SUB: begin
				work_we    = 1'b1;
				work_waddr = AW'(lud_idx(k_q, j_q, n_q));
				work_wdata = diff_sat;
				if (j_nx < n_q) begin
					j_d     = j_nx[IDX_W-1:0];
					state_d = ST_UPD_RD;
				end else if (k_nx < n_q) begin
					k_d     = k_nx[IDX_W-1:0];
					state_d = ST_COL_RD;
				end else begin
					i_d     = i_nx[IDX_W-1:0];
					state_d = ST_PIV_RD;
				end
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				out_valid = 1'b1;
				state_d   = ST_OUT_RD;
				if (j_nx == n_q) begin
					j_d = '0;
					i_d = i_nx[IDX_W-1:0];
					if (i_nx == n_q) begin
						out_last = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					j_d = j_nx[IDX_W-1:0];
				end
			end
			ST_FAIL: begin
				out_valid = 1'b1;
				out_value = '0;
				out_row   = '0;
				out_col   = '0;
				failed    = 1'b1;
				out_last  = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// checks
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("result strobe while idle");

	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> out_last)
		else $error("failure result without last marker");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |=> !busy)
		else $error("still busy after last result");

	a_load_stay: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !is_last) |=> !busy)
		else $error("run started without last marker");

endmodule
